>>> design/gasp_pkg.sv
`timescale 1ns / 1ps

package gasp_pkg;

  localparam int ATLAS_SIZE = 256;
  localparam int DIM_W      = 9;
  localparam int TEX_W      = 8;
  localparam int SUM_W      = 16;

  localparam logic [DIM_W:0]     ATLAS_LIM      = (DIM_W + 1)'(ATLAS_SIZE);
  localparam logic [SUM_W-1:0]   SUM_MAX        = '1;
  localparam logic [TEX_W-1:0]   ROTATION_RESET = TEX_W'(2);

  // depths are powers of two so the pointers wrap on their own
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  localparam logic MODE_RESET = 1'b1;
  localparam logic KIND_PLACE = 1'b0;
  localparam logic KIND_RECT  = 1'b1;

  typedef enum logic {
    OP_PLACE,
    OP_RESET
  } op_t;

  typedef enum logic [1:0] {
    S_DECIDE,
    S_MOD,
    S_PLACE,
    S_CLOSE
  } back_state_t;

  typedef struct packed {
    op_t              op;
    logic [DIM_W-1:0] glyph_width;
    logic [DIM_W-1:0] glyph_height;
    logic             first_glyph;
    logic             last_glyph;
  } cmd_t;

  typedef struct packed {
    logic             kind;
    logic [TEX_W-1:0] texture_index;
    logic [DIM_W-1:0] pos_x;
    logic [DIM_W-1:0] pos_y;
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
    logic [SUM_W-1:0] total_width;
    logic             texture_advanced;
    logic             last;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [TEX_W-1:0] dividend;
    logic [TEX_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [TEX_W-1:0] remainder;
  } mod_rsp_t;

endpackage

>>> design/glyph_atlas_shelf_packer.sv
`timescale 1ns / 1ps
// Each glyph passes the command queue, then the sequencer's decide and place states,
//   and the close state when the string's last segment closes; a segment that it closes
//   is pushed in decide. A packer reset item takes only the decide state.
// A texture advance after the rotation count shrank to or below the current texture first
//   computes the wrap in the serial remainder unit.
// Reset: synchronous rst empties both queues, zeroes the packer and sets the rotation to 2.

module glyph_atlas_shelf_packer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        mode,
  input  logic [gasp_pkg::DIM_W-1:0]  glyph_width,
  input  logic [gasp_pkg::DIM_W-1:0]  glyph_height,
  input  logic                        first_glyph,
  input  logic                        last_glyph,
  output logic                        empty,
  input  logic                        pop,
  output logic                        kind,
  output logic [gasp_pkg::TEX_W-1:0]  texture_index,
  output logic [gasp_pkg::DIM_W-1:0]  pos_x,
  output logic [gasp_pkg::DIM_W-1:0]  pos_y,
  output logic [gasp_pkg::DIM_W-1:0]  rect_width,
  output logic [gasp_pkg::DIM_W-1:0]  rect_height,
  output logic [gasp_pkg::SUM_W-1:0]  total_width,
  output logic                        texture_advanced,
  output logic                        last,
  input  logic                        cfg_wr_en,
  input  logic [gasp_pkg::TEX_W-1:0]  cfg_wr_data
);

  logic               cmd_valid;
  logic               cmd_pop;
  gasp_pkg::cmd_t     cmd;
  logic               res_full;
  logic               res_push;
  gasp_pkg::result_t  res;
  gasp_pkg::result_t  head;

  gasp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .mode         (mode),
    .glyph_width  (glyph_width),
    .glyph_height (glyph_height),
    .first_glyph  (first_glyph),
    .last_glyph   (last_glyph),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  gasp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res)
  );

  gasp_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign kind             = head.kind;
  assign texture_index    = head.texture_index;
  assign pos_x            = head.pos_x;
  assign pos_y            = head.pos_y;
  assign rect_width       = head.rect_width;
  assign rect_height      = head.rect_height;
  assign total_width      = head.total_width;
  assign texture_advanced = head.texture_advanced;
  assign last             = head.last;

endmodule

>>> design/gasp_front.sv
`timescale 1ns / 1ps

module gasp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        mode,
  input  logic [gasp_pkg::DIM_W-1:0]  glyph_width,
  input  logic [gasp_pkg::DIM_W-1:0]  glyph_height,
  input  logic                        first_glyph,
  input  logic                        last_glyph,
  output logic                        cmd_valid,
  output gasp_pkg::cmd_t              cmd,
  input  logic                        cmd_pop
);

  gasp_pkg::cmd_t                  entries [gasp_pkg::CQ_DEPTH];
  gasp_pkg::cmd_t                  cmd_in;
  logic [gasp_pkg::CQ_AW-1:0]      wr_ptr;
  logic [gasp_pkg::CQ_AW-1:0]      rd_ptr;
  logic [gasp_pkg::CQ_AW:0]        count;
  logic                            accept;
  logic                            deq;

  assign full      = (count == (gasp_pkg::CQ_AW + 1)'(gasp_pkg::CQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign accept    = push && !full;
  assign deq       = cmd_pop && cmd_valid;
  assign cmd       = entries[rd_ptr];

  always_comb begin
    cmd_in.glyph_width  = glyph_width;
    cmd_in.glyph_height = glyph_height;
    cmd_in.first_glyph  = first_glyph;
    cmd_in.last_glyph   = last_glyph;
    case (mode)
      gasp_pkg::MODE_RESET: cmd_in.op = gasp_pkg::OP_RESET;
      default:              cmd_in.op = gasp_pkg::OP_PLACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({accept, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/gasp_mod.sv
`timescale 1ns / 1ps

module gasp_mod (
  input  logic                clk,
  input  logic                rst,
  input  gasp_pkg::mod_req_t  req,
  output gasp_pkg::mod_rsp_t  rsp
);

  logic                           busy;
  logic                           done;
  logic [$clog2(gasp_pkg::TEX_W)-1:0] step;
  logic [gasp_pkg::TEX_W-1:0]     rem;
  logic [gasp_pkg::TEX_W-1:0]     rem_next;
  logic [gasp_pkg::TEX_W-1:0]     dvd;
  logic [gasp_pkg::TEX_W-1:0]     dsr;
  logic [gasp_pkg::TEX_W:0]       shifted;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem, dvd[gasp_pkg::TEX_W-1]};
    if (shifted >= {1'b0, dsr}) begin
      rem_next = gasp_pkg::TEX_W'(shifted - {1'b0, dsr});
    end else begin
      rem_next = shifted[gasp_pkg::TEX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem <= '0;
      dvd <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= dvd << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

>>> design/gasp_back.sv
`timescale 1ns / 1ps

module gasp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [gasp_pkg::TEX_W-1:0]  cfg_wr_data,
  input  logic                        cmd_valid,
  input  gasp_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  input  logic                        res_full,
  output logic                        res_push,
  output gasp_pkg::result_t           res
);

  localparam int DW = gasp_pkg::DIM_W;
  localparam int TW = gasp_pkg::TEX_W;
  localparam int SW = gasp_pkg::SUM_W;

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [DW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + (SW + 1)'(b);
    return s[SW] ? gasp_pkg::SUM_MAX : s[SW-1:0];
  endfunction

  gasp_pkg::back_state_t state, state_next;

  logic [DW-1:0] cursor_x, cursor_x_next;
  logic [DW-1:0] row_top, row_top_next;
  logic [DW-1:0] next_row_top, next_row_top_next;
  logic [DW-1:0] segment_start_x, segment_start_x_next;
  logic [DW-1:0] segment_top, segment_top_next;
  logic [DW-1:0] segment_height, segment_height_next;
  logic [TW-1:0] segment_texture, segment_texture_next;
  logic [TW-1:0] current_texture, current_texture_next;
  logic [SW-1:0] string_width, string_width_next;
  logic [TW-1:0] rotation;
  logic [DW-1:0] item_width, item_width_next;
  logic [DW-1:0] item_height, item_height_next;
  logic          item_last, item_last_next;
  logic          item_adv, item_adv_next;
  logic [TW-1:0] wrap_value, wrap_value_next;
  logic          wrap_ready, wrap_ready_next;

  gasp_pkg::mod_req_t mod_req;
  gasp_pkg::mod_rsp_t mod_rsp;

  // decide-stage view of one glyph
  logic [DW-1:0] ss0, st0, sh0, cx1, rt1, sh1, ss1, st1, pre_w;
  logic [TW-1:0] stex0, stex1, num, tex_adv;
  logic [SW-1:0] sw0, sw1, pre_sum;
  logic [TW:0]   inc;
  logic          brk, adv, pre_close, stale, need_mod;

  // place and close views
  logic [DW-1:0] pl_cursor, cl_w;
  logic [DW:0]   pl_top;
  logic [SW-1:0] cl_sum;
  logic          post;

  gasp_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  always_comb begin
    ss0   = cmd.first_glyph ? cursor_x : segment_start_x;
    st0   = cmd.first_glyph ? row_top : segment_top;
    sh0   = cmd.first_glyph ? '0 : segment_height;
    stex0 = cmd.first_glyph ? current_texture : segment_texture;
    sw0   = cmd.first_glyph ? '0 : string_width;

    brk   = ({1'b0, cursor_x} + {1'b0, cmd.glyph_width}) > gasp_pkg::ATLAS_LIM;
    rt1   = brk ? next_row_top : row_top;
    sh1   = brk ? '0 : sh0;
    cx1   = brk ? '0 : cursor_x;
    ss1   = brk ? '0 : ss0;
    st1   = brk ? next_row_top : st0;
    stex1 = brk ? current_texture : stex0;

    adv = (({1'b0, rt1} + {1'b0, cmd.glyph_height}) > gasp_pkg::ATLAS_LIM) ||
          (({1'b0, rt1} + {1'b0, sh1}) > gasp_pkg::ATLAS_LIM);

    pre_close = (brk && (cursor_x > ss0)) || (adv && (cx1 > ss1));
    pre_w     = cursor_x - ss0;
    pre_sum   = sat_add(sw0, pre_w);
    sw1       = pre_close ? pre_sum : sw0;

    num = (rotation == '0) ? TW'(1) : rotation;
    inc = {1'b0, current_texture} + (TW + 1)'(1);
    if (inc < {1'b0, num}) begin
      tex_adv = inc[TW-1:0];
      stale   = 1'b0;
    end else if (inc == {1'b0, num}) begin
      tex_adv = '0;
      stale   = 1'b0;
    end else begin
      tex_adv = wrap_value;
      stale   = 1'b1;
    end
    need_mod = adv && stale && !wrap_ready;

    pl_cursor = cursor_x + item_width;
    pl_top    = {1'b0, row_top} + {1'b0, item_height};
    post      = item_last && ((cursor_x > segment_start_x) || (item_width != '0));

    cl_w   = cursor_x - segment_start_x;
    cl_sum = sat_add(string_width, cl_w);
  end

  always_comb begin
    state_next           = state;
    cursor_x_next        = cursor_x;
    row_top_next         = row_top;
    next_row_top_next    = next_row_top;
    segment_start_x_next = segment_start_x;
    segment_top_next     = segment_top;
    segment_height_next  = segment_height;
    segment_texture_next = segment_texture;
    current_texture_next = current_texture;
    string_width_next    = string_width;
    item_width_next      = item_width;
    item_height_next     = item_height;
    item_last_next       = item_last;
    item_adv_next        = item_adv;
    wrap_value_next      = wrap_value;
    wrap_ready_next      = wrap_ready;
    cmd_pop              = 1'b0;
    res_push             = 1'b0;
    res                  = '0;
    mod_req.start        = 1'b0;
    mod_req.dividend     = inc[TW-1:0];
    mod_req.divisor      = num;

    case (state)
      gasp_pkg::S_DECIDE: begin
        if (cmd_valid) begin
          if (cmd.op == gasp_pkg::OP_RESET) begin
            cmd_pop              = 1'b1;
            cursor_x_next        = '0;
            row_top_next         = '0;
            next_row_top_next    = '0;
            segment_start_x_next = '0;
            segment_top_next     = '0;
            segment_height_next  = '0;
            segment_texture_next = '0;
            current_texture_next = '0;
            string_width_next    = '0;
            wrap_ready_next      = 1'b0;
          end else if (need_mod) begin
            mod_req.start = 1'b1;
            state_next    = gasp_pkg::S_MOD;
          end else if (!(pre_close && res_full)) begin
            cmd_pop = 1'b1;
            if (pre_close) begin
              res_push             = 1'b1;
              res.kind             = gasp_pkg::KIND_RECT;
              res.texture_index    = stex0;
              res.pos_x            = ss0;
              res.pos_y            = st0;
              res.rect_width       = pre_w;
              res.rect_height      = sh0;
              res.total_width      = pre_sum;
              res.texture_advanced = adv;
              res.last             = 1'b0;
            end
            if (adv) begin
              current_texture_next = tex_adv;
              cursor_x_next        = '0;
              row_top_next         = '0;
              next_row_top_next    = '0;
              segment_start_x_next = '0;
              segment_top_next     = '0;
              segment_height_next  = '0;
              segment_texture_next = tex_adv;
            end else begin
              cursor_x_next        = cx1;
              row_top_next         = rt1;
              segment_start_x_next = ss1;
              segment_top_next     = st1;
              segment_height_next  = sh1;
              segment_texture_next = stex1;
            end
            string_width_next = sw1;
            item_width_next   = cmd.glyph_width;
            item_height_next  = cmd.glyph_height;
            item_last_next    = cmd.last_glyph;
            item_adv_next     = adv;
            wrap_ready_next   = 1'b0;
            state_next        = gasp_pkg::S_PLACE;
          end
        end
      end

      gasp_pkg::S_MOD: begin
        if (mod_rsp.done) begin
          wrap_value_next = mod_rsp.remainder;
          wrap_ready_next = 1'b1;
          state_next      = gasp_pkg::S_DECIDE;
        end
      end

      gasp_pkg::S_PLACE: begin
        if (!res_full) begin
          res_push             = 1'b1;
          res.kind             = gasp_pkg::KIND_PLACE;
          res.texture_index    = current_texture;
          res.pos_x            = cursor_x;
          res.pos_y            = row_top;
          res.rect_width       = item_width;
          res.rect_height      = item_height;
          res.total_width      = string_width;
          res.texture_advanced = item_adv;
          res.last             = !post;
          cursor_x_next        = pl_cursor;
          if (item_height > segment_height) begin
            segment_height_next = item_height;
            if (pl_top > {1'b0, next_row_top}) begin
              next_row_top_next = pl_top[DW-1:0];
            end
          end
          if (post) begin
            state_next = gasp_pkg::S_CLOSE;
          end else begin
            if (item_last) begin
              segment_start_x_next = pl_cursor;
              segment_top_next     = row_top;
              segment_height_next  = '0;
              segment_texture_next = current_texture;
              string_width_next    = '0;
            end
            state_next = gasp_pkg::S_DECIDE;
          end
        end
      end

      gasp_pkg::S_CLOSE: begin
        if (!res_full) begin
          res_push             = 1'b1;
          res.kind             = gasp_pkg::KIND_RECT;
          res.texture_index    = segment_texture;
          res.pos_x            = segment_start_x;
          res.pos_y            = segment_top;
          res.rect_width       = cl_w;
          res.rect_height      = segment_height;
          res.total_width      = cl_sum;
          res.texture_advanced = item_adv;
          res.last             = 1'b1;
          segment_start_x_next = cursor_x;
          segment_top_next     = row_top;
          segment_height_next  = '0;
          segment_texture_next = current_texture;
          string_width_next    = '0;
          state_next           = gasp_pkg::S_DECIDE;
        end
      end

      default: state_next = gasp_pkg::S_DECIDE;
    endcase
  end

  always_ff @(posedge clk) begin
    item_width  <= item_width_next;
    item_height <= item_height_next;
    item_last   <= item_last_next;
    item_adv    <= item_adv_next;
    wrap_value  <= wrap_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= gasp_pkg::S_DECIDE;
      cursor_x        <= '0;
      row_top         <= '0;
      next_row_top    <= '0;
      segment_start_x <= '0;
      segment_top     <= '0;
      segment_height  <= '0;
      segment_texture <= '0;
      current_texture <= '0;
      string_width    <= '0;
      wrap_ready      <= 1'b0;
      rotation        <= gasp_pkg::ROTATION_RESET;
    end else begin
      state           <= state_next;
      cursor_x        <= cursor_x_next;
      row_top         <= row_top_next;
      next_row_top    <= next_row_top_next;
      segment_start_x <= segment_start_x_next;
      segment_top     <= segment_top_next;
      segment_height  <= segment_height_next;
      segment_texture <= segment_texture_next;
      current_texture <= current_texture_next;
      string_width    <= string_width_next;
      wrap_ready      <= wrap_ready_next;
      if (cfg_wr_en) begin
        rotation <= cfg_wr_data;
      end
    end
  end

endmodule

>>> design/gasp_resq.sv
`timescale 1ns / 1ps

module gasp_resq (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_push,
  input  gasp_pkg::result_t  res,
  output logic               res_full,
  output logic               empty,
  input  logic               pop,
  output gasp_pkg::result_t  head
);

  gasp_pkg::result_t           entries [gasp_pkg::RQ_DEPTH];
  logic [gasp_pkg::RQ_AW-1:0]  wr_ptr;
  logic [gasp_pkg::RQ_AW-1:0]  rd_ptr;
  logic [gasp_pkg::RQ_AW:0]    count;
  logic                        enq;
  logic                        deq;

  assign res_full = (count == (gasp_pkg::RQ_AW + 1)'(gasp_pkg::RQ_DEPTH));
  assign empty    = (count == '0);
  assign enq      = res_push && !res_full;
  assign deq      = pop && !empty;
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      entries[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({enq, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/gasp_chk.sv
`timescale 1ns / 1ps

module gasp_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic                        kind,
  input logic [gasp_pkg::TEX_W-1:0]  texture_index,
  input logic [gasp_pkg::DIM_W-1:0]  pos_x,
  input logic [gasp_pkg::DIM_W-1:0]  pos_y,
  input logic [gasp_pkg::DIM_W-1:0]  rect_width,
  input logic [gasp_pkg::DIM_W-1:0]  rect_height,
  input logic [gasp_pkg::SUM_W-1:0]  total_width,
  input logic                        texture_advanced,
  input logic                        last
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_advance_at_origin: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind == gasp_pkg::KIND_PLACE) && texture_advanced)
      |-> (pos_x == '0 && pos_y == '0))
    else $error("placement after texture advance not at origin");

  a_rect_nonempty: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind == gasp_pkg::KIND_RECT)) |-> (rect_width != '0))
    else $error("empty segment rectangle emitted");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(texture_index) &&
      $stable(pos_x) && $stable(pos_y) && $stable(rect_width) &&
      $stable(rect_height) && $stable(total_width) &&
      $stable(texture_advanced) && $stable(last)))
    else $error("waiting result changed");

endmodule

bind glyph_atlas_shelf_packer gasp_chk u_chk (.*);

>>> verif/glyph_atlas_shelf_packer_checker.sv
`timescale 1ns / 1ps

module glyph_atlas_shelf_packer_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        full,
  input  logic                        mode,
  input  logic [gasp_pkg::DIM_W-1:0]  glyph_width,
  input  logic [gasp_pkg::DIM_W-1:0]  glyph_height,
  input  logic                        first_glyph,
  input  logic                        last_glyph,
  input  logic                        empty,
  input  logic                        pop,
  input  logic                        kind,
  input  logic [gasp_pkg::TEX_W-1:0]  texture_index,
  input  logic [gasp_pkg::DIM_W-1:0]  pos_x,
  input  logic [gasp_pkg::DIM_W-1:0]  pos_y,
  input  logic [gasp_pkg::DIM_W-1:0]  rect_width,
  input  logic [gasp_pkg::DIM_W-1:0]  rect_height,
  input  logic [gasp_pkg::SUM_W-1:0]  total_width,
  input  logic                        texture_advanced,
  input  logic                        last,
  input  logic                        cfg_wr_en,
  input  logic [gasp_pkg::TEX_W-1:0]  cfg_wr_data,
  output int                          mismatch_count,
  output int                          results_owed
);

  logic [gasp_pkg::TEX_W-1:0] rotation;
  logic [gasp_pkg::DIM_W-1:0] cursor;
  logic [gasp_pkg::DIM_W-1:0] shelf_top;
  logic [gasp_pkg::DIM_W-1:0] next_shelf_top;
  logic [gasp_pkg::DIM_W-1:0] seg_x;
  logic [gasp_pkg::DIM_W-1:0] seg_top;
  logic [gasp_pkg::DIM_W-1:0] seg_height;
  logic [gasp_pkg::TEX_W-1:0] seg_texture;
  logic [gasp_pkg::TEX_W-1:0] texture;
  logic [gasp_pkg::SUM_W-1:0] string_sum;

  gasp_pkg::result_t owed_q[$];
  gasp_pkg::result_t step_q[$];

  initial begin
    mismatch_count = 0;
    results_owed = 0;
  end

  function automatic gasp_pkg::result_t make_result(
      input logic k, input logic [gasp_pkg::TEX_W-1:0] tex,
      input logic [gasp_pkg::DIM_W-1:0] x, input logic [gasp_pkg::DIM_W-1:0] y,
      input logic [gasp_pkg::DIM_W-1:0] w, input logic [gasp_pkg::DIM_W-1:0] h);
    gasp_pkg::result_t r;
    r = '0;
    r.kind = k;
    r.texture_index = tex;
    r.pos_x = x;
    r.pos_y = y;
    r.rect_width = w;
    r.rect_height = h;
    r.total_width = string_sum;
    return r;
  endfunction

  function automatic string show(input gasp_pkg::result_t r);
    return $sformatf("kind=%0d tex=%0d x=%0d y=%0d w=%0d h=%0d total=%0d adv=%0d last=%0d",
                     r.kind, r.texture_index, r.pos_x, r.pos_y, r.rect_width,
                     r.rect_height, r.total_width, r.texture_advanced, r.last);
  endfunction

  task automatic clear_packer();
    cursor = '0;
    shelf_top = '0;
    next_shelf_top = '0;
    seg_x = '0;
    seg_top = '0;
    seg_height = '0;
    seg_texture = '0;
    texture = '0;
    string_sum = '0;
  endtask

  task automatic start_segment();
    seg_x = cursor;
    seg_top = shelf_top;
    seg_height = '0;
    seg_texture = texture;
  endtask

  task automatic emit_segment();
    int sum;
    if (cursor > seg_x) begin
      sum = int'(string_sum) + int'(cursor) - int'(seg_x);
      string_sum = (sum > int'(gasp_pkg::SUM_MAX)) ? gasp_pkg::SUM_MAX :
                   gasp_pkg::SUM_W'(sum);
      step_q = {step_q, make_result(gasp_pkg::KIND_RECT, seg_texture, seg_x, seg_top,
                                    cursor - seg_x, seg_height)};
    end
  endtask

  task automatic place_glyph(input logic [gasp_pkg::DIM_W-1:0] gw,
                             input logic [gasp_pkg::DIM_W-1:0] gh,
                             input logic fg, input logic lg);
    int wrap;
    logic adv;
    gasp_pkg::result_t r;
    step_q.delete();
    adv = 1'b0;
    if (fg) begin
      start_segment();
      string_sum = '0;
    end
    if (int'(cursor) + int'(gw) > gasp_pkg::ATLAS_SIZE) begin
      emit_segment();
      cursor = '0;
      shelf_top = next_shelf_top;
      start_segment();
    end
    if (int'(shelf_top) + int'(gh) > gasp_pkg::ATLAS_SIZE ||
        int'(shelf_top) + int'(seg_height) > gasp_pkg::ATLAS_SIZE) begin
      wrap = (rotation == '0) ? 1 : int'(rotation);
      emit_segment();
      texture = gasp_pkg::TEX_W'((int'(texture) + 1) % wrap);
      cursor = '0;
      shelf_top = '0;
      next_shelf_top = '0;
      start_segment();
      adv = 1'b1;
    end
    step_q = {step_q, make_result(gasp_pkg::KIND_PLACE, texture, cursor, shelf_top, gw, gh)};
    cursor = cursor + gw;
    if (gh > seg_height) begin
      seg_height = gh;
      if (int'(gh) + int'(shelf_top) > int'(next_shelf_top))
        next_shelf_top = gh + shelf_top;
    end
    if (lg) begin
      emit_segment();
      start_segment();
    end
    foreach (step_q[i]) begin
      r = step_q[i];
      r.texture_advanced = adv;
      r.last = (i == step_q.size() - 1);
      owed_q = {owed_q, r};
    end
    if (lg)
      string_sum = '0;
  endtask

  task automatic check_result();
    gasp_pkg::result_t got;
    gasp_pkg::result_t want;
    got = {kind, texture_index, pos_x, pos_y, rect_width, rect_height, total_width,
           texture_advanced, last};
    if (owed_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: result with nothing owed: %s", $realtime, show(got));
    end else begin
      want = owed_q.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_packer();
      rotation = gasp_pkg::ROTATION_RESET;
      owed_q.delete();
    end else begin
      if (cfg_wr_en)
        rotation = cfg_wr_data;
      if (pop && !empty)
        check_result();
      if (push && !full) begin
        if (gasp_pkg::op_t'(mode) == gasp_pkg::OP_RESET)
          clear_packer();
        else
          place_glyph(glyph_width, glyph_height, first_glyph, last_glyph);
      end
    end
    results_owed <= owed_q.size();
  end

endmodule

>>> verif/glyph_atlas_shelf_packer_tb.sv
`timescale 1ns / 1ps

module glyph_atlas_shelf_packer_tb;

  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  logic mode;
  logic [gasp_pkg::DIM_W-1:0] glyph_width;
  logic [gasp_pkg::DIM_W-1:0] glyph_height;
  logic first_glyph;
  logic last_glyph;
  logic empty;
  logic pop;
  logic kind;
  logic [gasp_pkg::TEX_W-1:0] texture_index;
  logic [gasp_pkg::DIM_W-1:0] pos_x;
  logic [gasp_pkg::DIM_W-1:0] pos_y;
  logic [gasp_pkg::DIM_W-1:0] rect_width;
  logic [gasp_pkg::DIM_W-1:0] rect_height;
  logic [gasp_pkg::SUM_W-1:0] total_width;
  logic texture_advanced;
  logic last;
  logic cfg_wr_en;
  logic [gasp_pkg::TEX_W-1:0] cfg_wr_data;

  int mismatch_count;
  int results_owed;
  int tx_gap_pct;
  int rx_gap_pct;
  bit hold_request;

  glyph_atlas_shelf_packer uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode),
    .glyph_width(glyph_width), .glyph_height(glyph_height),
    .first_glyph(first_glyph), .last_glyph(last_glyph),
    .empty(empty), .pop(pop), .kind(kind), .texture_index(texture_index),
    .pos_x(pos_x), .pos_y(pos_y), .rect_width(rect_width), .rect_height(rect_height),
    .total_width(total_width), .texture_advanced(texture_advanced), .last(last),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  glyph_atlas_shelf_packer_checker placement_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode),
    .glyph_width(glyph_width), .glyph_height(glyph_height),
    .first_glyph(first_glyph), .last_glyph(last_glyph),
    .empty(empty), .pop(pop), .kind(kind), .texture_index(texture_index),
    .pos_x(pos_x), .pos_y(pos_y), .rect_width(rect_width), .rect_height(rect_height),
    .total_width(total_width), .texture_advanced(texture_advanced), .last(last),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .mismatch_count(mismatch_count), .results_owed(results_owed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_cycles(input int pct);
    if ($urandom_range(0, 99) >= pct)
      return 0;
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int rand_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85)
      return $urandom_range(0, 64);
    if (r < 95)
      return $urandom_range(65, 200);
    return $urandom_range(201, 256);
  endfunction

  function automatic int rand_height();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80)
      return $urandom_range(0, 48);
    if (r < 95)
      return $urandom_range(49, 160);
    return $urandom_range(161, 256);
  endfunction

  task automatic send(input logic m, input int w, input int h, input bit f, input bit l);
    int g;
    push <= 1'b1;
    mode <= m;
    glyph_width <= gasp_pkg::DIM_W'(w);
    glyph_height <= gasp_pkg::DIM_W'(h);
    first_glyph <= f;
    last_glyph <= l;
    do @(posedge clk); while (full);
    g = gap_cycles(tx_gap_pct);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (results_owed != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_rotation(input int value);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= gasp_pkg::TEX_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_strings(input int count);
    int placed;
    int len;
    int r;
    placed = 0;
    while (placed < count) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
          send(gasp_pkg::OP_PLACE, rand_width(), rand_height(), i == 0, i == len - 1);
        placed += len;
      end else if (r < 88) begin
        send(gasp_pkg::OP_RESET, $urandom_range(0, 256), $urandom_range(0, 256),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        send(gasp_pkg::OP_PLACE, rand_width(), rand_height(), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)));
        placed++;
      end
    end
  endtask

  initial begin
    int g;
    pop = 1'b0;
    forever begin
      if (hold_request) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      g = gap_cycles(rx_gap_pct);
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    mode = 1'b0;
    glyph_width = '0;
    glyph_height = '0;
    first_glyph = 1'b0;
    last_glyph = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    tx_gap_pct = 30;
    rx_gap_pct = 30;
    hold_request = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send(gasp_pkg::OP_PLACE, 10, 20, 1, 1);
    send(gasp_pkg::OP_PLACE, 100, 30, 1, 0);
    send(gasp_pkg::OP_PLACE, 100, 40, 0, 0);
    send(gasp_pkg::OP_PLACE, 100, 50, 0, 1);
    send(gasp_pkg::OP_PLACE, 0, 0, 1, 1);
    send(gasp_pkg::OP_PLACE, 256, 256, 1, 1);
    send(gasp_pkg::OP_PLACE, 50, 10, 1, 0);
    send(gasp_pkg::OP_PLACE, 60, 10, 1, 1);
    send(gasp_pkg::OP_PLACE, 20, 5, 0, 0);
    send(gasp_pkg::OP_PLACE, 30, 5, 0, 1);
    send(gasp_pkg::OP_RESET, 511, 511, 1, 1);
    for (int i = 0; i < 4; i++)
      send(gasp_pkg::OP_PLACE, 256, 256, i == 0, i == 3);
    send(gasp_pkg::OP_PLACE, 256, 0, 1, 1);
    send(gasp_pkg::OP_RESET, 0, 0, 0, 0);
    send(gasp_pkg::OP_PLACE, 255, 255, 0, 0);

    write_rotation(1);
    for (int i = 0; i < 3; i++)
      send(gasp_pkg::OP_PLACE, 256, 256, 1, 1);

    write_rotation(5);
    send(gasp_pkg::OP_RESET, 0, 0, 0, 0);
    for (int i = 0; i < 5; i++)
      send(gasp_pkg::OP_PLACE, 256, 256, i == 0, i == 4);
    write_rotation(3);
    send(gasp_pkg::OP_PLACE, 256, 256, 1, 0);
    send(gasp_pkg::OP_PLACE, 256, 256, 0, 1);

    write_rotation(0);
    for (int i = 0; i < 3; i++)
      send(gasp_pkg::OP_PLACE, 256, 256, 1, i == 2);

    write_rotation(255);
    random_strings(18);

    tx_gap_pct = 0;
    rx_gap_pct = 0;
    random_strings(12);

    hold_request = 1'b1;
    random_strings(18);

    tx_gap_pct = 30;
    rx_gap_pct = 30;
    send(gasp_pkg::OP_PLACE, 511, 0, 1, 0);
    for (int i = 0; i < 129; i++)
      send(gasp_pkg::OP_PLACE, 511, $urandom_range(0, 2), 0, i == 128);

    write_rotation(4);
    random_strings(18);

    write_rotation(2);
    tx_gap_pct = 60;
    rx_gap_pct = 60;
    random_strings(18);

    push <= 1'b0;
    @(posedge clk);
    while (results_owed != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
